FILE: hw/rtl/thsm_pkg.sv
// shared types and constants for the two-wire humidity sensor master
// used by thsm_ctrl, thsm_dpath and the top level; no dependencies
package thsm_pkg;

  localparam int unsigned InW   = 8;
  localparam int unsigned OutW  = 72;
  localparam int unsigned OffW  = 12;
  localparam int unsigned StepW = 4;
  localparam int unsigned AccW  = 56;

  localparam logic [OffW-1:0] OffsetReset = 12'd3970;

  localparam logic [1:0] ActIdle    = 2'd0;
  localparam logic [1:0] ActMeasure = 2'd1;
  localparam logic [1:0] ActReset   = 2'd2;
  localparam logic [1:0] ActSpare   = 2'd3;

  localparam logic [7:0] CmdTemperature = 8'h03;
  localparam logic [7:0] CmdHumidity    = 8'h05;

  // calculation steps
  localparam logic [StepW-1:0] CsMulK1   = 4'd0;
  localparam logic [StepW-1:0] CsMulK2   = 4'd1;
  localparam logic [StepW-1:0] CsMulSq   = 4'd2;
  localparam logic [StepW-1:0] CsMulK3   = 4'd3;
  localparam logic [StepW-1:0] CsMulLo   = 4'd4;
  localparam logic [StepW-1:0] CsMulHi   = 4'd5;
  localparam logic [StepW-1:0] CsAddHi   = 4'd6;
  localparam logic [StepW-1:0] CsClamp   = 4'd7;
  localparam logic [StepW-1:0] CsRound   = 4'd8;

  typedef struct packed {
    logic             tick;
    logic             calc;
    logic [StepW-1:0] step;
  } thsm_cmd_t;

  typedef struct packed {
    logic need_calc;
  } thsm_sts_t;

endpackage

FILE: hw/rtl/thsm_ctrl.sv
// controller: request handshake and sequencing of the result calculation
// depends on thsm_pkg
module thsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  thsm_pkg::thsm_sts_t sts_i,
  output thsm_pkg::thsm_cmd_t cmd_o
);
  import thsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_OUT  = 3'b100
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             tick;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign tick        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (tick) begin
          step_d  = CsMulK1;
          state_d = sts_i.need_calc ? ST_CALC : ST_OUT;
        end
      end
      ST_CALC: begin
        if (step_q == CsRound) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o.tick = tick;
  assign cmd_o.calc = (state_q == ST_CALC);
  assign cmd_o.step = step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= CsMulK1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_calc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && step_q == CsRound) |=> out_valid_o)
    else $error("calculation did not end in output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.calc |-> step_q <= CsRound) else $error("step out of range");
`endif

endmodule

FILE: hw/rtl/thsm_dpath.sv
// datapath: bus phase sequencer, raw readings and fixed-point compensation
// depends on thsm_pkg
module thsm_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  thsm_pkg::thsm_cmd_t    cmd_i,
  output thsm_pkg::thsm_sts_t    sts_o,
  input  logic [1:0]             action_i,
  input  logic                   data_in_i,
  input  logic                   cfg_we_i,
  input  logic [thsm_pkg::OffW-1:0] cfg_wdata_i,
  output logic [thsm_pkg::OutW-1:0] result_o
);
  import thsm_pkg::*;

  typedef enum logic [26:0] {
    PH_IDLE     = 27'd1,
    PH_S0       = 27'd2,
    PH_S1       = 27'd4,
    PH_S2       = 27'd8,
    PH_S3       = 27'd16,
    PH_S4       = 27'd32,
    PH_S5       = 27'd64,
    PH_CMD_LO   = 27'd128,
    PH_CMD_HI   = 27'd256,
    PH_ACK_LO   = 27'd512,
    PH_ACK_HI   = 27'd1024,
    PH_WAIT     = 27'd2048,
    PH_MSB_HI   = 27'd4096,
    PH_MSB_LO   = 27'd8192,
    PH_MACK1_LO = 27'd16384,
    PH_MACK1_HI = 27'd32768,
    PH_LSB_HI   = 27'd65536,
    PH_LSB_LO   = 27'd131072,
    PH_MACK2_LO = 27'd262144,
    PH_MACK2_HI = 27'd524288,
    PH_CRC_HI   = 27'd1048576,
    PH_CRC_LO   = 27'd2097152,
    PH_END_LO   = 27'd4194304,
    PH_END_HI   = 27'd8388608,
    PH_FINISH   = 27'd16777216,
    PH_RST_HI   = 27'd33554432,
    PH_RST_LO   = 27'd67108864
  } phase_e;

  localparam logic signed [36:0] K0 = 37'sd42949673;
  localparam logic signed [36:0] K1 = 37'sd343597;
  localparam logic signed [36:0] K2 = 37'sd685262;
  localparam logic signed [36:0] K3 = 37'sd15762529976;
  localparam logic signed [AccW-1:0] K4 = 56'sd879093906145;
  localparam logic signed [AccW-1:0] HumHi = 56'sd42520176230400;
  localparam logic signed [AccW-1:0] HumLo = 56'sd42949672960;
  localparam logic signed [AccW-1:0] Half = 56'sd2147483648;

  phase_e      phase_q, phase_d, ph_eff;
  logic [3:0]  bc_q, bc_d;
  logic [7:0]  sb_q, sb_d;
  logic [15:0] rawt_q, rawt_d, rawh_q, rawh_d;
  logic        hum_q, hum_d, err_q, err_d;
  logic        clk_q, clk_d, dlow_q, dlow_d, busy_q, busy_d, done_q, done_d;
  logic [OffW-1:0] off_q;
  logic [7:0]  cmd_byte;
  logic        cbit;

  logic signed [16:0] tres_q;
  logic [13:0]        hres_q;
  logic [35:0]        c_q;
  logic signed [AccW-1:0] mul_q, acc_q, mul_p, rnd;
  logic signed [36:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [17:0] t_w;
  logic signed [18:0] d_w;

  assign cmd_byte = hum_q ? CmdHumidity : CmdTemperature;
  assign cbit     = cmd_byte[~bc_q[2:0]];

  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    sb_d    = sb_q;
    rawt_d  = rawt_q;
    rawh_d  = rawh_q;
    hum_d   = hum_q;
    err_d   = err_q;
    clk_d   = 1'b0;
    dlow_d  = 1'b0;
    busy_d  = 1'b1;
    done_d  = 1'b0;
    ph_eff  = phase_q;
    if (phase_q == PH_IDLE) begin
      if (action_i == ActMeasure) begin
        err_d  = 1'b0;
        hum_d  = 1'b0;
        rawt_d = '0;
        ph_eff = PH_S0;
      end else if (action_i == ActReset) begin
        bc_d   = '0;
        ph_eff = PH_RST_HI;
      end
    end
    case (ph_eff)
      PH_IDLE: busy_d = 1'b0;
      PH_S0: begin clk_d = 1'b1; phase_d = PH_S1; end
      PH_S1: begin clk_d = 1'b1; dlow_d = 1'b1; phase_d = PH_S2; end
      PH_S2: begin dlow_d = 1'b1; phase_d = PH_S3; end
      PH_S3: begin clk_d = 1'b1; dlow_d = 1'b1; phase_d = PH_S4; end
      PH_S4: begin clk_d = 1'b1; phase_d = PH_S5; end
      PH_S5: begin bc_d = '0; phase_d = PH_CMD_LO; end
      PH_CMD_LO: begin dlow_d = ~cbit; phase_d = PH_CMD_HI; end
      PH_CMD_HI: begin
        clk_d  = 1'b1;
        dlow_d = ~cbit;
        if (bc_q >= 4'd7) begin
          bc_d    = '0;
          phase_d = PH_ACK_LO;
        end else begin
          bc_d    = bc_q + 4'd1;
          phase_d = PH_CMD_LO;
        end
      end
      PH_ACK_LO: phase_d = PH_ACK_HI;
      PH_ACK_HI: begin
        clk_d = 1'b1;
        if (data_in_i) begin
          err_d = 1'b1;
          if (!hum_q) begin
            hum_d   = 1'b1;
            rawh_d  = '0;
            phase_d = PH_S0;
          end else begin
            phase_d = PH_FINISH;
          end
        end else begin
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!data_in_i) begin
          bc_d    = '0;
          sb_d    = '0;
          phase_d = PH_MSB_HI;
        end
      end
      PH_MSB_HI, PH_LSB_HI, PH_CRC_HI: begin
        clk_d = 1'b1;
        sb_d  = {sb_q[6:0], data_in_i};
        case (ph_eff)
          PH_MSB_HI: phase_d = PH_MSB_LO;
          PH_LSB_HI: phase_d = PH_LSB_LO;
          default:   phase_d = PH_CRC_LO;
        endcase
      end
      PH_MSB_LO, PH_LSB_LO, PH_CRC_LO: begin
        if (bc_q >= 4'd7) begin
          bc_d = '0;
          case (ph_eff)
            PH_MSB_LO: begin
              if (hum_q) rawh_d = {sb_q, rawh_q[7:0]};
              else       rawt_d = {sb_q, rawt_q[7:0]};
              phase_d = PH_MACK1_LO;
            end
            PH_LSB_LO: begin
              if (hum_q) rawh_d = {rawh_q[15:8], sb_q};
              else       rawt_d = {rawt_q[15:8], sb_q};
              phase_d = PH_MACK2_LO;
            end
            default: phase_d = PH_END_LO;
          endcase
        end else begin
          bc_d = bc_q + 4'd1;
          case (ph_eff)
            PH_MSB_LO: phase_d = PH_MSB_HI;
            PH_LSB_LO: phase_d = PH_LSB_HI;
            default:   phase_d = PH_CRC_HI;
          endcase
        end
      end
      PH_MACK1_LO: begin dlow_d = 1'b1; phase_d = PH_MACK1_HI; end
      PH_MACK2_LO: begin dlow_d = 1'b1; phase_d = PH_MACK2_HI; end
      PH_MACK1_HI, PH_MACK2_HI: begin
        clk_d   = 1'b1;
        dlow_d  = 1'b1;
        bc_d    = '0;
        sb_d    = '0;
        phase_d = (ph_eff == PH_MACK1_HI) ? PH_LSB_HI : PH_CRC_HI;
      end
      PH_END_LO: phase_d = PH_END_HI;
      PH_END_HI: begin
        clk_d = 1'b1;
        if (!hum_q) begin
          hum_d   = 1'b1;
          rawh_d  = '0;
          phase_d = PH_S0;
        end else begin
          phase_d = PH_FINISH;
        end
      end
      PH_FINISH: begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        phase_d = PH_IDLE;
      end
      PH_RST_HI: begin clk_d = 1'b1; phase_d = PH_RST_LO; end
      PH_RST_LO: begin
        if (bc_q >= 4'd15) begin
          bc_d    = '0;
          phase_d = PH_IDLE;
        end else begin
          bc_d    = bc_q + 4'd1;
          phase_d = PH_RST_HI;
        end
      end
      default: begin
        busy_d  = 1'b0;
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign sts_o.need_calc = (ph_eff == PH_FINISH);

  // compensation arithmetic, one shared multiplier
  assign t_w = $signed({2'b0, rawt_q}) - $signed({6'b0, off_q});
  assign d_w = 19'(t_w) - 19'sd2500;

  always_comb begin
    mul_a = K1;
    mul_b = $signed({3'b0, rawh_q});
    case (cmd_i.step)
      CsMulK1: mul_a = K1;
      CsMulK2: mul_a = K2;
      CsMulSq: mul_a = $signed({1'b0, mul_q[35:0]});
      CsMulK3: mul_a = K3;
      CsMulLo: begin mul_a = $signed({19'b0, c_q[17:0]}); mul_b = d_w; end
      CsMulHi: begin mul_a = $signed({19'b0, c_q[35:18]}); mul_b = d_w; end
      default: mul_a = K1;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign rnd   = acc_q + Half;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      case (cmd_i.step)
        CsMulK1: mul_q <= mul_p;
        CsMulK2: begin
          c_q   <= mul_q[35:0] + 36'(K0);
          mul_q <= mul_p;
          acc_q <= -K4;
        end
        CsMulSq: mul_q <= mul_p;
        CsMulK3: begin acc_q <= acc_q - mul_q; mul_q <= mul_p; end
        CsMulLo: begin acc_q <= acc_q + mul_q; mul_q <= mul_p; end
        CsMulHi: begin acc_q <= acc_q + mul_q; mul_q <= mul_p; end
        CsAddHi: acc_q <= acc_q + (mul_q <<< 18);
        CsClamp: begin
          if (acc_q > HumHi)      acc_q <= HumHi;
          else if (acc_q < HumLo) acc_q <= HumLo;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bc_q    <= '0;
      sb_q    <= '0;
      rawt_q  <= '0;
      rawh_q  <= '0;
      hum_q   <= 1'b0;
      err_q   <= 1'b0;
      clk_q   <= 1'b0;
      dlow_q  <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      off_q   <= OffsetReset;
      tres_q  <= '0;
      hres_q  <= '0;
    end else begin
      if (cfg_we_i) off_q <= cfg_wdata_i;
      if (cmd_i.tick) begin
        phase_q <= phase_d;
        bc_q    <= bc_d;
        sb_q    <= sb_d;
        rawt_q  <= rawt_d;
        rawh_q  <= rawh_d;
        hum_q   <= hum_d;
        err_q   <= err_d;
        clk_q   <= clk_d;
        dlow_q  <= dlow_d;
        busy_q  <= busy_d;
        done_q  <= done_d;
      end
      if (cmd_i.calc && cmd_i.step == CsRound) begin
        tres_q <= t_w[16:0];
        hres_q <= rnd[45:32];
      end
    end
  end

  assign result_o = {4'b0, rawh_q, rawt_q, hres_q, tres_q,
                     err_q, done_q, busy_q, dlow_q, clk_q};

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && phase_q == PH_IDLE)) else $error("done outside idle");
  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_RST_HI && phase_q != PH_RST_LO) |-> bc_q <= 4'd7)
    else $error("bit count out of range");
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase not one-hot");
`endif

endmodule

FILE: hw/rtl/two_wire_humidity_sensor_master.sv
// one request in, one result out; each request is accepted and then its result
// is output; on the finishing tick the 9-step shared multiplier sequence that
// compensates humidity runs in between; a new request is taken once the result
// is taken; async active-low reset clears control, bus and raw state and the
// results, and sets the temperature offset to 3970; multiplier regs keep state
// top level: joins thsm_ctrl and thsm_dpath, depends on thsm_pkg
module two_wire_humidity_sensor_master (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [thsm_pkg::InW-1:0]   s_axis_tdata,  // action[1:0], data_in[2]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // clock_out, data_low, busy_res, done_res, ack_error, temperature[21:5],
  // humidity[35:22], temperature_raw[51:36], humidity_raw[67:52]
  output logic [thsm_pkg::OutW-1:0]  m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [thsm_pkg::OffW-1:0]  cfg_wdata_i
);
  import thsm_pkg::*;

  thsm_cmd_t cmd;
  thsm_sts_t sts;

  thsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  thsm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tdata[1:0]),
    .data_in_i   (s_axis_tdata[2]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (m_axis_tdata)
  );

endmodule
